@@ src/stepper_ramp_pulse_sequencer_assert.svh @@
// Assertion macros for the step-pulse sequencer.
// Both macros expect signals named clk and rst_n in the scope of use.
`ifndef STEPPER_RAMP_PULSE_SEQUENCER_ASSERT_SVH
`define STEPPER_RAMP_PULSE_SEQUENCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRPS_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sequencer check failed");
`define SRPS_CHECK_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("sequencer check failed");
`else
`define SRPS_CHECK(lbl, prop)
`define SRPS_CHECK_NEXT(lbl, cond, prop)
`endif
`endif

@@ src/srps_pkg.sv @@
package srps_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int HALF_NUM_DEF   = 500000;

  localparam int REQ_W   = 20;
  localparam int RATE_W  = 16;
  localparam int RAMP_W  = 16;
  localparam int HALF_W  = 19;
  localparam int SENT_W  = 20;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 3;
  localparam int STAT_W  = 3;

  localparam logic [RATE_W-1:0] START_RATE_RST  = 16'd250;
  localparam logic [RATE_W-1:0] CRUISE_RATE_RST = 16'd1600;
  localparam logic [RAMP_W-1:0] RAMP_RST        = 16'd1;
  localparam logic [REQ_W-1:0]  DEPART_RST      = 20'd842;

  typedef enum logic [STAT_W-1:0] {
    ST_STARTED   = 3'd0,
    ST_PULSE     = 3'd1,
    ST_COMPLETED = 3'd2,
    ST_LIMIT     = 3'd3,
    ST_ABORTED   = 3'd4,
    ST_IDLE      = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQUESTED = 3'd0,
    CFG_MOVE_UP   = 3'd1,
    CFG_START     = 3'd2,
    CFG_CRUISE    = 3'd3,
    CFG_RAMP      = 3'd4,
    CFG_DEPARTURE = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_DIV,
    S_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_mul;
    logic load_sum;
    logic div_start;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pulse;
    logic div_busy;
  } dp_stat_t;

endpackage

@@ src/srps_if.sv @@
interface srps_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic top_pressed;
  logic bottom_pressed;
  logic abort_request;

  modport source (output valid, output cmd, output top_pressed, output bottom_pressed,
                  output abort_request, input ready);
  modport sink (input valid, input cmd, input top_pressed, input bottom_pressed,
                input abort_request, output ready);
endinterface

interface srps_out_if;
  logic                         valid;
  logic                         ready;
  srps_pkg::status_t            status;
  logic [srps_pkg::RATE_W-1:0]  pulse_rate;
  logic [srps_pkg::HALF_W-1:0]  half_period_us;
  logic [srps_pkg::SENT_W-1:0]  pulses_sent;
  logic                         direction_level;

  modport source (output valid, output status, output pulse_rate, output half_period_us,
                  output pulses_sent, output direction_level, input ready);
  modport sink (input valid, input status, input pulse_rate, input half_period_us,
                input pulses_sent, input direction_level, output ready);
endinterface

@@ src/srps_div.sv @@
module srps_div #(
  parameter int N_W = 33,
  parameter int D_W = 17
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic [N_W-1:0] quotient
);
  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   q_r, q_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [D_W:0]     rem_sh;
  logic [D_W:0]     diff;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    rem_sh = {rem_r, q_r[N_W-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    if (!diff[D_W]) begin
      rem_nxt = diff[D_W-1:0];
    end else begin
      rem_nxt = rem_sh[D_W-1:0];
    end
    q_nxt = {q_r[N_W-2:0], ~diff[D_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(N_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;
endmodule

@@ src/srps_ctrl.sv @@
module srps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output srps_pkg::ctrl_cmd_t cmd,
  input  srps_pkg::dp_stat_t  stat
);
  import srps_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && out_free && stat.pulse) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DIV;
      S_DIV:  state_nxt = S_WAIT;
      S_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == S_IDLE) && out_free;
    cmd.accept    = in_ready && in_valid;
    cmd.load_mul  = (state_r == S_MUL);
    cmd.load_sum  = (state_r == S_SUM);
    cmd.div_start = (state_r == S_DIV);
    cmd.finish    = (state_r == S_DONE) && out_free;
    // Starts, stops and idle slots are answered in the cycle after acceptance; pulses at
    // the end of the sequence.
    out_valid_nxt = (out_valid_r && !out_ready) || (cmd.accept && !stat.pulse) || cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

@@ src/srps_dpath.sv @@
module srps_dpath #(
  parameter int COUNT_BITS = srps_pkg::COUNT_BITS_DEF,
  parameter int HALF_NUM   = srps_pkg::HALF_NUM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [srps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srps_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_cmd,
  input  logic                           in_top,
  input  logic                           in_bottom,
  input  logic                           in_abort,
  input  srps_pkg::ctrl_cmd_t            cmd,
  output srps_pkg::dp_stat_t             stat,
  output srps_pkg::status_t              out_status,
  output logic [srps_pkg::RATE_W-1:0]    out_rate,
  output logic [srps_pkg::HALF_W-1:0]    out_half,
  output logic [srps_pkg::SENT_W-1:0]    out_sent,
  output logic                           out_dir
);
  import srps_pkg::*;

  localparam int CW   = COUNT_BITS;
  localparam int CMPW = ((CW > REQ_W) ? CW : REQ_W) + 1;
  localparam int HPW  = $clog2(HALF_NUM + 1);
  localparam int D2N  = HPW + RAMP_W;
  localparam int NUMW = 2 * RATE_W;
  localparam logic [D2N-1:0] HN_X = D2N'(HALF_NUM);

  // Configuration registers
  logic [REQ_W-1:0]  req_r;
  logic              up_r;
  logic [RATE_W-1:0] start_r, cruise_r;
  logic [RAMP_W-1:0] ramp_r;
  logic [REQ_W-1:0]  dep_r;

  // Move state
  logic [CW-1:0]     sent_r;
  logic              active_r, lb_r, lt_r;
  logic [RAMP_W-1:0] u_r;

  // Pulse arithmetic
  logic [RAMP_W-1:0] m_r;
  logic [NUMW-1:0]   p1_r, p2_r, num_r;
  logic [D2N-1:0]    hu_r;
  logic              sat_r;

  logic [CMPW-1:0]   sent_x, req_x, dep_x, rem_x, mm, m_full;
  logic              done_c, limit_c, pulse_c, stop_c;
  status_t           imm_status;
  logic [REQ_W-1:0]  half_req, u_min;
  logic [RAMP_W-1:0] u_start;
  logic [CW-1:0]     sent_inc;

  logic [NUMW:0]     dvd1;
  logic [RAMP_W:0]   dsr1;
  logic [NUMW:0]     q1;
  logic [D2N-1:0]    q2;
  logic              busy1, busy2;

  always_comb begin
    sent_x  = CMPW'(sent_r);
    req_x   = CMPW'(req_r);
    dep_x   = CMPW'(dep_r);
    done_c  = sent_x >= req_x;
    limit_c = (up_r && in_top) || (!up_r && in_bottom) ||
              (lb_r && (sent_x >= dep_x) && in_bottom) ||
              (lt_r && (sent_x >= dep_x) && in_top);
    pulse_c = in_cmd && active_r && !done_c && !in_abort && !limit_c;
    stop_c  = in_cmd && active_r && !pulse_c;

    if (!in_cmd) begin
      imm_status = ST_STARTED;
    end else if (!active_r) begin
      imm_status = ST_IDLE;
    end else if (done_c) begin
      imm_status = ST_COMPLETED;
    end else if (in_abort) begin
      imm_status = ST_ABORTED;
    end else if (limit_c) begin
      imm_status = ST_LIMIT;
    end else begin
      imm_status = ST_PULSE;
    end

    // Ramp position: distance to the nearer end of the move, clamped to the ramp.
    rem_x  = req_x - sent_x - CMPW'(1);
    mm     = (sent_x < rem_x) ? sent_x : rem_x;
    m_full = (mm < CMPW'(u_r)) ? mm : CMPW'(u_r);

    half_req = req_r >> 1;
    if (half_req == '0) begin
      half_req = REQ_W'(1);
    end
    u_min = (REQ_W'(ramp_r) < half_req) ? REQ_W'(ramp_r) : half_req;
    if (u_min == '0) begin
      u_min = REQ_W'(1);
    end
    u_start = u_min[RAMP_W-1:0];

    sent_inc = sent_r + CW'(1);

    dvd1 = {num_r, 1'b0} + (NUMW + 1)'(u_r);
    dsr1 = {u_r, 1'b0};
  end

  assign stat.pulse    = pulse_c;
  assign stat.div_busy = busy1 || busy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r    <= '0;
      up_r     <= 1'b0;
      start_r  <= START_RATE_RST;
      cruise_r <= CRUISE_RATE_RST;
      ramp_r   <= RAMP_RST;
      dep_r    <= DEPART_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REQUESTED: req_r    <= cfg_wdata[REQ_W-1:0];
        CFG_MOVE_UP:   up_r     <= cfg_wdata[0];
        CFG_START:     start_r  <= cfg_wdata[RATE_W-1:0];
        CFG_CRUISE:    cruise_r <= cfg_wdata[RATE_W-1:0];
        CFG_RAMP:      ramp_r   <= cfg_wdata[RAMP_W-1:0];
        CFG_DEPARTURE: dep_r    <= cfg_wdata[REQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r   <= '0;
      active_r <= 1'b0;
      lb_r     <= 1'b0;
      lt_r     <= 1'b0;
      u_r      <= RAMP_W'(1);
    end else if (cmd.accept && !in_cmd) begin
      sent_r   <= '0;
      active_r <= 1'b1;
      lb_r     <= up_r && in_bottom;
      lt_r     <= !up_r && in_top;
      u_r      <= u_start;
    end else if (cmd.accept && stop_c) begin
      active_r <= 1'b0;
    end else if (cmd.finish) begin
      sent_r <= sent_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && pulse_c) begin
      m_r <= m_full[RAMP_W-1:0];
    end
    if (cmd.load_mul) begin
      p1_r <= start_r * (u_r - m_r);
      p2_r <= cruise_r * m_r;
      hu_r <= HN_X * D2N'(u_r);
    end
    // The weighted sum never exceeds the larger rate times the ramp, so it fits.
    if (cmd.load_sum) begin
      num_r <= p1_r + p2_r;
    end
    if (cmd.div_start) begin
      sat_r <= num_r < NUMW'(u_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !pulse_c) begin
      out_status <= imm_status;
      out_rate   <= '0;
      out_half   <= '0;
      out_sent   <= in_cmd ? SENT_W'(sent_r) : '0;
      out_dir    <= !up_r;
    end else if (cmd.finish) begin
      out_status <= ST_PULSE;
      out_rate   <= q1[RATE_W-1:0];
      out_half   <= sat_r ? HALF_W'(HALF_NUM) : HALF_W'(q2);
      out_sent   <= SENT_W'(sent_inc);
      out_dir    <= !up_r;
    end
  end

  // Rounded rate: (2*num + u) / (2*u).
  srps_div #(.N_W(NUMW + 1), .D_W(RAMP_W + 1)) u_rate_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd1),
    .divisor  (dsr1),
    .busy     (busy1),
    .quotient (q1)
  );

  // Half period: numerator * u / num.
  srps_div #(.N_W(D2N), .D_W(NUMW)) u_half_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (hu_r),
    .divisor  (num_r),
    .busy     (busy2),
    .quotient (q2)
  );
endmodule

@@ src/stepper_ramp_pulse_sequencer.sv @@
// Channel  Role    Handshake      Payload
// in_chan  sink    valid/ready    cmd, top_pressed, bottom_pressed, abort_request
// out_chan source  valid/ready    status, pulse_rate, half_period_us, pulses_sent,
//                                 direction_level
// cfg      write   cfg_we         cfg_index, cfg_wdata
//
// A start request, a stop and an idle slot answer in the cycle after acceptance.
// A pulse request passes through the multiply, sum and divide-start states, then waits
// for the bit-serial half-period and rate dividers, which run alongside each other.
// Reset is synchronous; no clearing pass follows.
// A result waits in the output register; no request is taken until it has gone.
module stepper_ramp_pulse_sequencer #(
  parameter int COUNT_BITS            = srps_pkg::COUNT_BITS_DEF,
  parameter int HALF_PERIOD_NUMERATOR = srps_pkg::HALF_NUM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  srps_in_if.sink                        in_chan,
  srps_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [srps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srps_pkg::CFG_W-1:0]     cfg_wdata
);
  import srps_pkg::*;

  `include "stepper_ramp_pulse_sequencer_assert.svh"

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;

  srps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  srps_dpath #(
    .COUNT_BITS (COUNT_BITS),
    .HALF_NUM   (HALF_PERIOD_NUMERATOR)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_cmd     (in_chan.cmd),
    .in_top     (in_chan.top_pressed),
    .in_bottom  (in_chan.bottom_pressed),
    .in_abort   (in_chan.abort_request),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (out_chan.status),
    .out_rate   (out_chan.pulse_rate),
    .out_half   (out_chan.half_period_us),
    .out_sent   (out_chan.pulses_sent),
    .out_dir    (out_chan.direction_level)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  // Only pulse results carry a rate and a half period.
  `SRPS_CHECK(a_nopulse_zero, (out_valid && out_chan.status != ST_PULSE) |-> (out_chan.pulse_rate == '0 && out_chan.half_period_us == '0))
  // A request is never taken while an untaken result blocks the output register.
  `SRPS_CHECK(a_no_overwrite, (in_chan.valid && in_ready) |-> !(out_valid && !out_chan.ready))
  // The dividers are idle when started and busy just after.
  `SRPS_CHECK(a_div_idle, cmd.div_start |-> !stat.div_busy)
  `SRPS_CHECK_NEXT(a_div_runs, cmd.div_start, stat.div_busy)
endmodule

@@ test/stepper_ramp_pulse_sequencer_test.sv @@
`timescale 1ns / 1ps

module stepper_ramp_pulse_sequencer_test;
  import srps_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES      = 24;
  localparam int PHASE_ITEMS = 56;

  typedef struct packed {
    logic cmd;
    logic top;
    logic bottom;
    logic abort_req;
  } request_t;

  typedef struct {
    status_t             status;
    logic [RATE_W-1:0]   rate;
    logic [HALF_W-1:0]   half;
    logic [SENT_W-1:0]   sent;
    logic                dir;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  srps_in_if  in_if ();
  srps_out_if out_if ();

  stepper_ramp_pulse_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies, as the block should hold them.
  logic [REQ_W-1:0]  req_cfg    = '0;
  logic              up_cfg     = 1'b0;
  logic [RATE_W-1:0] start_cfg  = START_RATE_RST;
  logic [RATE_W-1:0] cruise_cfg = CRUISE_RATE_RST;
  logic [RAMP_W-1:0] ramp_cfg   = RAMP_RST;
  logic [REQ_W-1:0]  depart_cfg = DEPART_RST;

  // Move state.
  logic [SENT_W-1:0] sent_cnt    = '0;
  logic              moving      = 1'b0;
  logic              leave_bottom = 1'b0;
  logic              leave_top   = 1'b0;
  logic [RAMP_W-1:0] ramp_used   = 16'd1;

  request_t requests_waiting[$];
  outcome_t outcomes_due[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  logic pressure_on = 1'b0;
  int hold_cnt;
  int quiet_cycles;
  int failures = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Works out the report for one request and advances the move state.
  function automatic outcome_t step_outcome(request_t r);
    outcome_t o;
    longint unsigned u, m, num, s, rq, q;
    o.status = ST_IDLE;
    o.rate   = '0;
    o.half   = '0;
    s  = sent_cnt;
    rq = req_cfg;
    if (!r.cmd) begin
      u = rq / 2;
      if (u < 1) u = 1;
      if (ramp_cfg < u) u = ramp_cfg;
      if (u < 1) u = 1;
      ramp_used    = u[RAMP_W-1:0];
      leave_bottom = up_cfg && r.bottom;
      leave_top    = !up_cfg && r.top;
      sent_cnt     = '0;
      moving       = 1'b1;
      o.status     = ST_STARTED;
    end else if (moving) begin
      if (s >= rq) begin
        moving   = 1'b0;
        o.status = ST_COMPLETED;
      end else if (r.abort_req) begin
        moving   = 1'b0;
        o.status = ST_ABORTED;
      end else if ((up_cfg && r.top) || (!up_cfg && r.bottom) ||
                   (leave_bottom && s >= depart_cfg && r.bottom) ||
                   (leave_top && s >= depart_cfg && r.top)) begin
        moving   = 1'b0;
        o.status = ST_LIMIT;
      end else begin
        u = ramp_used;
        if (u < 1) u = 1;
        m = s;
        if (rq - s - 1 < m) m = rq - s - 1;
        if (u < m) m = u;
        num = longint'(start_cfg) * (u - m) + longint'(cruise_cfg) * m;
        q = (2 * num + u) / (2 * u);
        o.rate = q[RATE_W-1:0];
        if (num < u) q = HALF_NUM_DEF;
        else q = (longint'(HALF_NUM_DEF) * u) / num;
        o.half   = q[HALF_W-1:0];
        sent_cnt = sent_cnt + 1'b1;
        o.status = ST_PULSE;
      end
    end
    o.sent = sent_cnt;
    o.dir  = !up_cfg;
    return o;
  endfunction

  function automatic void check_field(string what, logic [19:0] want, logic [19:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      failures++;
    end
  endfunction

  function automatic void add(int cmd, int top, int bottom, int abort_req);
    request_t r;
    r.cmd       = cmd[0];
    r.top       = top[0];
    r.bottom    = bottom[0];
    r.abort_req = abort_req[0];
    requests_waiting.push_back(r);
  endfunction

  // Request driver.
  always @(posedge clk) begin
    request_t seen, nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        seen.cmd       = in_if.cmd;
        seen.top       = in_if.top_pressed;
        seen.bottom    = in_if.bottom_pressed;
        seen.abort_req = in_if.abort_request;
        outcomes_due.push_back(step_outcome(seen));
      end
      if (!in_if.valid || in_if.ready) begin
        if (requests_waiting.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = requests_waiting.pop_front();
          in_if.valid          <= 1'b1;
          in_if.cmd            <= nxt.cmd;
          in_if.top_pressed    <= nxt.top;
          in_if.bottom_pressed <= nxt.bottom;
          in_if.abort_request  <= nxt.abort_req;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the result side, counted once pressure is switched on.
  always @(posedge clk) begin
    if (!pressure_on) begin
      hold_cnt <= 0;
    end else if (hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, got status %0d",
                   $time, out_if.status);
          failures++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("status", 20'(want.status), 20'(out_if.status));
          check_field("pulse_rate", 20'(want.rate), 20'(out_if.pulse_rate));
          check_field("half_period_us", 20'(want.half), 20'(out_if.half_period_us));
          check_field("pulses_sent", want.sent, out_if.pulses_sent);
          check_field("direction_level", 20'(want.dir), 20'(out_if.direction_level));
        end
      end
      out_if.ready <= !(pressure_on && hold_cnt < HOLD_CYCLES) &&
                      ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no handshake and no register write.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_if.valid && in_if.ready) ||
        (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_REQUESTED: req_cfg    = val[REQ_W-1:0];
      CFG_MOVE_UP:   up_cfg     = val[0];
      CFG_START:     start_cfg  = val[RATE_W-1:0];
      CFG_CRUISE:    cruise_cfg = val[RATE_W-1:0];
      CFG_RAMP:      ramp_cfg   = val[RAMP_W-1:0];
      CFG_DEPARTURE: depart_cfg = val[REQ_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits at falling edges so that queue and handshake state have settled.
  task automatic drain();
    while (requests_waiting.size() > 0 || in_if.valid || outcomes_due.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
      1: begin send_idle_pct <= 63; stall_pct <= 0;  end
      2: begin send_idle_pct <= 0;  stall_pct <= 63; end
      default: begin send_idle_pct <= 32; stall_pct <= 32; end
    endcase
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3, 4, 5: return RATE_W'($urandom_range(1, 3000));
      default: return RATE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_config();
    int k;
    k = $urandom_range(19);
    if (k == 0) cfg_write(CFG_REQUESTED, 20'hFFFFF);
    else if (k == 1) cfg_write(CFG_REQUESTED, CFG_W'($urandom_range(0, 2)));
    else cfg_write(CFG_REQUESTED, CFG_W'($urandom_range(0, 40)));
    cfg_write(CFG_MOVE_UP, CFG_W'($urandom_range(1)));
    cfg_write(CFG_START, CFG_W'(pick_rate()));
    cfg_write(CFG_CRUISE, CFG_W'(pick_rate()));
    k = $urandom_range(9);
    if (k == 0) cfg_write(CFG_RAMP, '0);
    else if (k == 1) cfg_write(CFG_RAMP, 20'hFFFF);
    else cfg_write(CFG_RAMP, CFG_W'($urandom_range(1, 25)));
    k = $urandom_range(19);
    if (k == 0) cfg_write(CFG_DEPARTURE, 20'hFFFFF);
    else if (k == 1) cfg_write(CFG_DEPARTURE, '0);
    else cfg_write(CFG_DEPARTURE, CFG_W'($urandom_range(0, 20)));
  endtask

  // One move: a start, then slots with the departed switch released after the
  // departure distance. A few slots carry faults or plain noise.
  function automatic int random_move();
    request_t r;
    int n, i;
    logic departs;
    departs = 1'($urandom_range(1));
    r = '0;
    if (up_cfg) r.bottom = departs;
    else r.top = departs;
    if ($urandom_range(9) == 0) r = request_t'(4'($urandom_range(15)));
    r.cmd = 1'b0;
    requests_waiting.push_back(r);
    n = (req_cfg <= 60) ? int'(req_cfg) + 1 + int'($urandom_range(1)) :
                          int'($urandom_range(5, 60));
    for (i = 0; i < n; i++) begin
      r = '0;
      r.cmd = 1'b1;
      if (departs && (i < depart_cfg || $urandom_range(19) == 0)) begin
        if (up_cfg) r.bottom = 1'b1;
        else r.top = 1'b1;
      end
      if ($urandom_range(49) == 0) r.abort_req = 1'b1;
      if ($urandom_range(49) == 0) begin
        if (up_cfg) r.top = 1'b1;
        else r.bottom = 1'b1;
      end
      if ($urandom_range(32) == 0) r = request_t'(4'($urandom_range(15)));
      requests_waiting.push_back(r);
    end
    return n + 1;
  endfunction

  initial begin
    int p, count;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_REQUESTED;
    cfg_wdata            = '0;
    in_if.valid          = 1'b0;
    in_if.cmd            = 1'b0;
    in_if.top_pressed    = 1'b0;
    in_if.bottom_pressed = 1'b0;
    in_if.abort_request  = 1'b0;
    out_if.ready         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a slot while idle, then a move of zero pulses.
    add(1, 0, 0, 0);
    add(0, 0, 0, 0);
    add(1, 0, 0, 0);
    add(1, 0, 0, 0);
    drain();

    // Upward move leaving the pressed bottom switch, with the default rates.
    cfg_write(CFG_REQUESTED, 20'd6);
    cfg_write(CFG_MOVE_UP, 20'd1);
    cfg_write(CFG_RAMP, 20'd2);
    cfg_write(CFG_DEPARTURE, 20'd2);
    add(0, 0, 1, 0);
    repeat (3) add(1, 0, 1, 0);
    add(0, 0, 0, 0);
    repeat (7) add(1, 0, 0, 0);
    drain();

    // Downward move at the extremes: zero start rate, full cruise rate,
    // zero ramp and the longest move.
    cfg_write(CFG_MOVE_UP, 20'd0);
    cfg_write(CFG_START, 20'd0);
    cfg_write(CFG_CRUISE, 20'hFFFF);
    cfg_write(CFG_RAMP, 20'd0);
    cfg_write(CFG_REQUESTED, 20'hFFFFF);
    cfg_write(CFG_DEPARTURE, 20'hFFFFF);
    add(0, 1, 0, 0);
    add(1, 1, 0, 0);
    add(1, 1, 0, 0);
    add(1, 0, 1, 0);
    add(0, 0, 0, 0);
    add(1, 1, 1, 1);
    add(0, 0, 0, 0);
    add(1, 0, 0, 0);
    add(0, 0, 0, 0);
    add(1, 0, 0, 0);
    drain();

    for (p = 0; p < PHASES; p++) begin
      set_idling(p % 4);
      if (p == 5) pressure_on <= 1'b1;
      random_config();
      count = 0;
      while (count < PHASE_ITEMS) count += random_move();
      drain();
    end

    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
